>>> rtl/core/nlmv_pkg.sv
// ----------------------------------------------------------------------------
// nlmv_pkg
// shared constants, types and codes of the neighbor label majority vote block
// ----------------------------------------------------------------------------
package nlmv_pkg;

  // table sizes (node count and label count are powers of two)
  localparam int NUM_NODES     = 1024;
  localparam int NUM_LABELS    = 64;
  localparam int MAX_NEIGHBORS = 32;

  // field widths fixed by the interface
  localparam int OPCODE_W = 2;
  localparam int IN_IDX_W = 11;
  localparam int LABEL_W  = 6;
  localparam int ROW_W    = 10;
  localparam int COUNT_W  = 6;

  // derived widths
  localparam int NODE_W = $clog2(NUM_NODES);
  localparam int SLOT_W = $clog2(NUM_LABELS);
  localparam int VOTE_W = $clog2(MAX_NEIGHBORS + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_VOTE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_VOTE,
    CMD_READ
  } cmd_kind_t;

  // classified request, index already wrapped to a table address
  typedef struct packed {
    cmd_kind_t           kind;
    logic [NODE_W-1:0]   idx;
    logic [LABEL_W-1:0]  label;
    logic                last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPLY,
    ST_LOOKUP,
    ST_TALLY,
    ST_EMIT
  } back_state_t;

endpackage

>>> rtl/core/neighbor_label_majority_vote.sv
// ----------------------------------------------------------------------------
// neighbor_label_majority_vote
// label table with per-row neighbor majority vote and write-back of winners
// ----------------------------------------------------------------------------
// requests queue in the front while it has room; the back end walks one
//   command at a time through its table ports, and a read or last vote
//   waits while the previous result is still held and not taken by the sink
// reset: synchronous rst clears queue, row counter, counts and best; label
//   table contents stay undefined until written
module neighbor_label_majority_vote (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [nlmv_pkg::OPCODE_W-1:0]       opcode,
  input  logic [nlmv_pkg::IN_IDX_W-1:0]       node_index,
  input  logic [nlmv_pkg::LABEL_W-1:0]        label_in,
  input  logic                                last,
  // result channel
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic                                is_vote,
  output logic [nlmv_pkg::ROW_W-1:0]          row_index,
  output logic [nlmv_pkg::LABEL_W-1:0]        label_out
);
  import nlmv_pkg::*;

  // classified command handed from the front queue to the back end
  logic  cmd_valid;
  cmd_t  cmd;
  logic  cmd_pop;

  // front: takes requests while the queue has room, wraps indices
  // (vote neighbors are 1-based) and drops the unused opcode
  nlmv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .opcode     (opcode),
    .node_index (node_index),
    .label_in   (label_in),
    .last       (last),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // back: label lookup, count read-modify-write with running best,
  // and on the last neighbor the winner goes out and back into the table;
  // a held result stalls only reads and last votes, not loads or other votes
  nlmv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .is_vote   (is_vote),
    .row_index (row_index),
    .label_out (label_out)
  );

endmodule

>>> rtl/core/nlmv_front.sv
// ----------------------------------------------------------------------------
// nlmv_front
// accepts requests, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
module nlmv_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [nlmv_pkg::OPCODE_W-1:0]       opcode,
  input  logic [nlmv_pkg::IN_IDX_W-1:0]       node_index,
  input  logic [nlmv_pkg::LABEL_W-1:0]        label_in,
  input  logic                                last,
  output logic                                cmd_valid,
  output nlmv_pkg::cmd_t                      cmd,
  input  logic                                cmd_pop
);
  import nlmv_pkg::*;

  cmd_t               queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  cmd_t               cls;
  logic               cls_keep;
  logic               push;
  logic [NODE_W-1:0]  base_idx;

  // classify: wrap indices, drop unused opcode
  always_comb begin
    base_idx  = node_index[NODE_W-1:0];
    cls.label = label_in;
    cls.last  = last;
    cls.kind  = CMD_LOAD;
    cls.idx   = base_idx;
    cls_keep  = 1'b1;
    unique case (opcode)
      OP_LOAD: cls.kind = CMD_LOAD;
      OP_VOTE: begin
        cls.kind = CMD_VOTE;
        cls.idx  = NODE_W'(base_idx - NODE_W'(1));
      end
      OP_READ: cls.kind = CMD_READ;
      default: cls_keep = 1'b0;
    endcase
  end

  assign req_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign push      = req_valid && req_ready && cls_keep;
  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'((int'(wr_ptr) + 1) % QUEUE_DEPTH);
      end
      if (cmd_pop) begin
        rd_ptr <= QPTR_W'((int'(rd_ptr) + 1) % QUEUE_DEPTH);
      end
      if (push && !cmd_pop) begin
        fill <= QCNT_W'(fill + QCNT_W'(1));
      end else if (!push && cmd_pop) begin
        fill <= QCNT_W'(fill - QCNT_W'(1));
      end
    end
  end

endmodule

>>> rtl/core/nlmv_back.sv
// ----------------------------------------------------------------------------
// nlmv_back
// executes queued commands against the label and count tables
// ----------------------------------------------------------------------------
module nlmv_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  input  nlmv_pkg::cmd_t                      cmd,
  output logic                                cmd_pop,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic                                is_vote,
  output logic [nlmv_pkg::ROW_W-1:0]          row_index,
  output logic [nlmv_pkg::LABEL_W-1:0]        label_out
);
  import nlmv_pkg::*;

  back_state_t state;
  back_state_t state_next;

  // label table, undefined until written
  logic [LABEL_W-1:0] label_mem [NUM_NODES];
  logic [LABEL_W-1:0] label_q;
  logic               lbl_we;
  logic [NODE_W-1:0]  lbl_waddr;
  logic [LABEL_W-1:0] lbl_wdata;
  logic               lbl_re;

  // count table, cleared per row through valid bits
  logic [COUNT_W-1:0] count_mem [NUM_LABELS];
  logic [COUNT_W-1:0] count_q;
  logic [NUM_LABELS-1:0] count_vld;
  logic               cnt_re;
  logic               cnt_we;

  cmd_t               cur;
  logic [LABEL_W-1:0] cur_lab;
  logic [LABEL_W-1:0] best_label;
  logic [COUNT_W-1:0] best_count;
  logic [VOTE_W-1:0]  votes_taken;
  logic [NODE_W-1:0]  current_row;

  logic               row_clear;
  logic               row_adv;
  logic               take_vote;
  logic               rsp_load;
  logic               rsp_load_vote;
  logic               slot_free;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] cnt_old;
  logic [COUNT_W-1:0] cnt_new;
  logic               lead;

  assign slot      = cur_lab[SLOT_W-1:0];
  assign cnt_old   = count_vld[slot] ? count_q : '0;
  assign cnt_new   = (cnt_old < COUNT_MAX) ? COUNT_W'(cnt_old + COUNT_W'(1)) : cnt_old;
  assign lead      = (cnt_new > best_count) ||
                     ((cnt_new == best_count) && (cur_lab < best_label));
  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next    = state;
    cmd_pop       = 1'b0;
    lbl_we        = 1'b0;
    lbl_waddr     = cmd.idx;
    lbl_wdata     = cmd.label;
    lbl_re        = 1'b0;
    cnt_re        = 1'b0;
    cnt_we        = 1'b0;
    take_vote     = 1'b0;
    row_clear     = 1'b0;
    row_adv       = 1'b0;
    rsp_load      = 1'b0;
    rsp_load_vote = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_LOAD: begin
              lbl_we    = 1'b1;
              row_clear = 1'b1;
            end
            CMD_READ: begin
              lbl_re     = 1'b1;
              state_next = ST_REPLY;
            end
            CMD_VOTE: begin
              lbl_re     = 1'b1;
              state_next = ST_LOOKUP;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_REPLY: begin
        if (slot_free) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        cnt_re     = 1'b1;
        state_next = ST_TALLY;
      end
      ST_TALLY: begin
        if (votes_taken < VOTE_W'(MAX_NEIGHBORS)) begin
          cnt_we    = 1'b1;
          take_vote = 1'b1;
        end
        state_next = cur.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) begin
          rsp_load      = 1'b1;
          rsp_load_vote = 1'b1;
          lbl_we        = 1'b1;
          lbl_waddr     = current_row;
          lbl_wdata     = best_label;
          row_clear     = 1'b1;
          row_adv       = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (lbl_we) begin
      label_mem[lbl_waddr] <= lbl_wdata;
    end
    if (lbl_re) begin
      label_q <= label_mem[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[slot] <= cnt_new;
    end
    if (cnt_re) begin
      count_q <= count_mem[label_q[SLOT_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state == ST_LOOKUP) begin
      cur_lab <= label_q;
    end
    if (rsp_load) begin
      is_vote   <= rsp_load_vote;
      row_index <= rsp_load_vote ? ROW_W'(current_row) : ROW_W'(cur.idx);
      label_out <= rsp_load_vote ? best_label : label_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_vld   <= '0;
      best_label  <= '0;
      best_count  <= '0;
      votes_taken <= '0;
      current_row <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (row_clear) begin
        count_vld   <= '0;
        best_label  <= '0;
        best_count  <= '0;
        votes_taken <= '0;
        current_row <= row_adv ? NODE_W'(current_row + NODE_W'(1)) : '0;
      end else if (take_vote) begin
        count_vld[slot] <= 1'b1;
        votes_taken     <= VOTE_W'(votes_taken + VOTE_W'(1));
        if (lead) begin
          best_count <= cnt_new;
          best_label <= cur_lab;
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_tally_after_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TALLY) |-> ($past(state) == ST_LOOKUP))
    else $error("tally without a preceding label lookup");

  a_votes_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(votes_taken) <= MAX_NEIGHBORS)
    else $error("vote counter ran past the neighbor limit");

  a_best_within_votes: assert property (@(posedge clk) disable iff (rst)
    int'(best_count) <= int'(votes_taken))
    else $error("best count exceeds votes taken in row");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_REPLY || $past(state) == ST_EMIT))
    else $error("result raised outside reply or emit step");
`endif

endmodule
